@@ sv/rgs_pkg.sv @@
// ----------------------------------------------------------------------------
// rgs_pkg : shared types and constants for the Roberts gradient sharpener
// Register indexes, band modes, pixel type, per-lane helpers.
// ----------------------------------------------------------------------------
package rgs_pkg;

  localparam int MaxColsDef = 1024;
  localparam int MaxRowsDef = 4095;
  localparam int NumBands   = 3;

  localparam logic [1:0] REG_COLS  = 2'd0;
  localparam logic [1:0] REG_ROWS  = 2'd1;
  localparam logic [1:0] REG_MODE  = 2'd2;
  localparam logic [1:0] REG_SPARE = 2'd3;   // no register behind it

  localparam logic [1:0] MODE_GRAY  = 2'd0;
  localparam logic [1:0] MODE_COLOR = 2'd1;
  localparam logic [1:0] MODE_PASS  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;  // behaves as pass

  localparam logic [7:0] PIX_MAX = 8'd255;

  typedef logic [23:0] pix_t;

  // one pending emission: kind of processing and position
  typedef struct packed {
    logic        sharp;   // apply sharpening
    logic [11:0] row;
    logic [9:0]  col;
  } emit_t;

  function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
    absdiff8 = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [7:0] sat_add8(input logic [7:0] p, input logic [8:0] g);
    logic [9:0] s;
    s = {2'b0, p} + {1'b0, g};
    sat_add8 = (s > 10'd255) ? PIX_MAX : s[7:0];
  endfunction

endpackage

@@ sv/roberts_gradient_sharpen.sv @@
// ----------------------------------------------------------------------------
// roberts_gradient_sharpen : Roberts-cross sharpening of a pixel stream
// One-row line store, three band lanes with serial square root, merge stage.
// ----------------------------------------------------------------------------
// channel | dir | contents
// in_     | in  | pixel of three bands, raster order
// out_    | out | sharpened pixel with row and column, tlast on final result
// cfg_    | in  | register writes: cols, rows, mode
//
// An item is taken in the idle state; the read state starts the lanes on
// the registered line-store read; the calc state is direct in gray mode
// and runs a serial square root in other modes (one root bit per cycle);
// then 0 to 3 results, one per cycle with out_tready. One item at a time.
// rst_n is synchronous active low; it clears control state, left_r and al_r.
// The line store is never cleared; each entry is written in row 0 first.
// Output stalls hold the emit index; input is not taken meanwhile.
// ----------------------------------------------------------------------------
module roberts_gradient_sharpen
  import rgs_pkg::*;
#(
  parameter int MAX_COLS = MaxColsDef,
  parameter int MAX_ROWS = MaxRowsDef
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [11:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_band0, pixel_band1, pixel_band2
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_row, out_col, out_band0..2, 2'b0 fill
  output logic        out_tlast   // last_of_run
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;

  logic [2:0]  state_r, state_nxt;
  logic [10:0] cols_r;
  logic [11:0] rows_r;
  logic [1:0]  mode_r;
  logic [CW:0] ecols;
  logic [RW:0] erows;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  pix_t        x_r, left_r, al_r, above_r;
  pix_t        mem [MAX_COLS];
  emit_t       em_r [3];
  pix_t        ep_r [3];     // pass values
  logic [1:0]  n_r, k_r;
  logic [2:0]  ldone;
  pix_t        lane_px, opx;
  logic        lstart;

  // effective sizes, clamped
  always_comb begin
    ecols = (cols_r < 11'd2) ? (CW+1)'(2)
          : ({21'd0, cols_r} > MAX_COLS) ? (CW+1)'(MAX_COLS) : (CW+1)'(cols_r);
    erows = (rows_r < 12'd2) ? (RW+1)'(2)
          : ({20'd0, rows_r} > MAX_ROWS) ? (RW+1)'(MAX_ROWS) : (RW+1)'(rows_r);
  end

  assign in_tready = (state_r == ST_IDLE);
  assign lstart = (state_r == ST_READ);

  // line store, registered read
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mem[col_r] <= in_tdata;
      above_r    <= mem[col_r];
    end
  end

  genvar b;
  generate
    for (b = 0; b < NumBands; b++) begin : g_lane
      rgs_lane u_lane (
        .clk(clk), .rst_n(rst_n), .start(lstart), .mode(mode_r),
        .p(al_r[8*b +: 8]), .right(above_r[8*b +: 8]),
        .below(left_r[8*b +: 8]), .br(x_r[8*b +: 8]),
        .done(ldone[b]), .res(lane_px[8*b +: 8]));
    end
  endgenerate

  rgs_merge u_merge (.mode(mode_r), .em(em_r[k_r]), .pass_px(ep_r[k_r]),
                     .lane_px(lane_px), .px(opx));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_CALC;
      ST_CALC: if (&ldone) state_nxt = (n_r == 2'd0) ? ST_IDLE : ST_EMIT;
      ST_EMIT: if (out_tready && k_r == n_r - 2'd1) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic        em_sharp, em_edge, em_last;
  logic [1:0]  n_nxt, last_slot;
  logic [CW-1:0] ncol;
  logic [RW-1:0] nrow;
  always_comb begin
    em_sharp = (row_r != '0) && (col_r != '0);
    em_edge  = (row_r != '0) && ({1'b0, col_r} == ecols - 1'b1);
    em_last  = ({1'b0, row_r} == erows - 1'b1);
    // an edge result always follows a sharpened one
    n_nxt     = {1'b0, em_sharp} + {1'b0, em_edge} + {1'b0, em_last};
    last_slot = em_edge ? 2'd2 : (em_sharp ? 2'd1 : 2'd0);
    ncol = col_r + 1'b1;
    nrow = row_r;
    if ({1'b0, col_r} == ecols - 1'b1) begin
      ncol = '0;
      nrow = ({1'b0, row_r} == erows - 1'b1) ? '0 : row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cols_r  <= 11'd1024;
      rows_r  <= 12'd768;
      mode_r  <= MODE_GRAY;
      row_r   <= '0;
      col_r   <= '0;
      left_r  <= '0;
      al_r    <= '0;
      n_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && (cfg_addr inside {REG_COLS, REG_ROWS, REG_MODE})) begin
        case (cfg_addr)
          REG_COLS: cols_r <= cfg_wdata[10:0];
          REG_ROWS: rows_r <= cfg_wdata;
          REG_MODE: mode_r <= cfg_wdata[1:0];
          default: ;
        endcase
        row_r <= '0;
        col_r <= '0;
      end
      if (in_tvalid && in_tready) begin
        x_r <= in_tdata;
        if (em_sharp) begin
          em_r[0] <= '{1'b1, 12'(row_r - 1'b1), 10'(col_r - 1'b1)};
          ep_r[0] <= al_r;
        end
        if (em_edge) begin
          em_r[1] <= '{1'b0, 12'(row_r - 1'b1), 10'(col_r)};
          ep_r[1] <= mem[col_r];
        end
        if (em_last) begin
          em_r[last_slot] <= '{1'b0, 12'(row_r), 10'(col_r)};
          ep_r[last_slot] <= in_tdata;
        end
        n_r   <= n_nxt;
        k_r   <= '0;
        row_r <= nrow;
        col_r <= ncol;
      end
      if (state_r == ST_CALC && (&ldone)) begin
        al_r   <= above_r;
        left_r <= x_r;
      end
      if (state_r == ST_EMIT && out_tready) k_r <= k_r + 2'd1;
    end
  end

  assign out_tvalid = (state_r == ST_EMIT);
  assign out_tlast  = (k_r == n_r - 2'd1);
  assign out_tdata  = {2'b0, opx, em_r[k_r].col, em_r[k_r].row};

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("busy accept");
  a_read_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_CALC)) else $error("seq");
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (k_r < n_r)) else $error("k range");
`endif

endmodule

@@ sv/rgs_lane.sv @@
// ----------------------------------------------------------------------------
// rgs_lane : one band of the sharpener
// Computes gradient sum of squares, then an iterative integer square root
// (one result bit per cycle) and saturating add; gray mode adds |t1-t2|.
// ----------------------------------------------------------------------------
module rgs_lane
  import rgs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,     // load operands
  input  logic [1:0] mode,
  input  logic [7:0] p,
  input  logic [7:0] right,
  input  logic [7:0] below,
  input  logic [7:0] br,
  output logic       done,
  output logic [7:0] res
);

  logic [16:0] rem_r, rem_nxt;   // remaining radicand
  logic [7:0]  root_r, root_nxt;
  logic [7:0]  p_r, p_nxt;
  logic [3:0]  step_r, step_nxt; // 8 = idle
  logic        gray_r, gray_nxt;
  logic [7:0]  gray_g_r, gray_g_nxt;
  logic [7:0]  d1, d2, t1, t2;
  logic [15:0] sq1, sq2;
  logic [16:0] trial;
  logic [2:0]  bitpos;
  logic [7:0]  root_fin;

  always_comb begin
    d1  = absdiff8(p, br);
    d2  = absdiff8(below, right);
    t1  = absdiff8(p, below);
    t2  = absdiff8(p, right);
    sq1 = d1 * d1;
    sq2 = d2 * d2;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    p_nxt      = p_r;
    step_nxt   = step_r;
    gray_nxt   = gray_r;
    gray_g_nxt = gray_g_r;
    bitpos = 3'd7 - step_r[2:0];
    // trial = (2*root + 2^bit) << bit, restoring digit step
    trial = ({9'd0, root_r} << ({1'b0, bitpos} + 4'd1)) | (17'd1 << {bitpos, 1'b0});
    if (start) begin
      rem_nxt    = {1'b0, sq1} + {1'b0, sq2};
      root_nxt   = '0;
      p_nxt      = p;
      step_nxt   = 4'd0;
      gray_nxt   = (mode == MODE_GRAY);
      gray_g_nxt = absdiff8(t1, t2);
    end else if (!step_r[3]) begin
      if (rem_r >= trial) begin
        rem_nxt  = rem_r - trial;
        root_nxt = root_r | (8'd1 << bitpos);
      end
      step_nxt = step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 4'd8;
    end else begin
      step_r <= step_nxt;
    end
    rem_r    <= rem_nxt;
    root_r   <= root_nxt;
    p_r      <= p_nxt;
    gray_r   <= gray_nxt;
    gray_g_r <= gray_g_nxt;
  end

  assign done = (step_r == 4'd7) || (gray_r && step_r == 4'd0);
  // final digit folded in combinationally at step 7
  assign root_fin = (rem_r >= trial) ? (root_r | 8'd1) : root_r;
  assign res = gray_r ? sat_add8(p_r, {1'b0, gray_g_r})
                      : sat_add8(p_r, {1'b0, root_fin});

endmodule

@@ sv/rgs_merge.sv @@
// ----------------------------------------------------------------------------
// rgs_merge : combines lane results into one output pixel
// Chooses sharpened or pass value per mode and masks bands in gray mode.
// ----------------------------------------------------------------------------
module rgs_merge
  import rgs_pkg::*;
(
  input  logic [1:0] mode,
  input  emit_t      em,
  input  pix_t       pass_px,
  input  pix_t       lane_px,
  output pix_t       px
);

  always_comb begin
    if (em.sharp && (mode == MODE_GRAY || mode == MODE_COLOR)) px = lane_px;
    else px = pass_px;
    if (mode == MODE_GRAY) px = {16'd0, px[7:0]};
  end

endmodule
